### src/line_plane_intersection_assert.svh
// Assertion macros shared by the line-plane intersection RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINE_PLANE_INTERSECTION_ASSERT_SVH
`define LINE_PLANE_INTERSECTION_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define LPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define LPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/lpi_pkg.sv
// Types, widths, register codes and arithmetic helpers of the line-plane
// intersection block. Depends on nothing; used by every RTL file.
package lpi_pkg;

    // Fixed-point format and derived widths.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FM_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W     = FM_W + 2;
    localparam int HIT_W     = FM_W + 1;
    localparam int QUO_W     = DATA_W - 1;
    localparam int INT_W     = QUO_W - FRAC_BITS;
    localparam int REM_W     = SUM_W + FRAC_BITS;
    localparam int TRY_W     = SUM_W + QUO_W;
    localparam int OVF_W     = SUM_W + INT_W;
    localparam int THR_W     = 31;
    localparam int IDX_W     = 3;

    // Saturation limits of a result word.
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Reset values of the plane registers.
    localparam logic signed [DATA_W-1:0] ONE_FIX   = DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam logic [THR_W-1:0]         THR_RESET = THR_W'(1);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PLANE_A   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PLANE_B   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_PLANE_C   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PLANE_D   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(4);

    // One line: origin and direction.
    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } t_lpi_in;

    // One result: hit point, line parameter and parallel flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] hit_x;
        logic signed [DATA_W-1:0] hit_y;
        logic signed [DATA_W-1:0] hit_z;
        logic signed [DATA_W-1:0] line_param;
        logic                     parallel;
    } t_lpi_out;

    // Item data and flags that ride along the divider stages.
    typedef struct packed {
        t_lpi_in item;
        logic    neg;
        logic    par;
        logic    ovf;
    } t_lpi_side;

    // Floor shift of a full product, sign extended to the sum width.
    function automatic logic signed [SUM_W-1:0] fm_ext(input logic signed [PROD_W-1:0] p);
        return SUM_W'($signed(p[PROD_W-1:FRAC_BITS]));
    endfunction

    // Magnitude of a signed sum.
    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] n;
        n = -v;
        return v[SUM_W-1] ? n : v;
    endfunction

    // Origin plus the floor-shifted product, saturated to a word.
    function automatic logic signed [DATA_W-1:0] add_sat(
        input logic signed [DATA_W-1:0] o,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [HIT_W-1:0] s;
        s = HIT_W'(o) + HIT_W'($signed(p[PROD_W-1:FRAC_BITS]));
        if (s > HIT_W'(S_MAX)) begin
            return S_MAX;
        end else if (s < HIT_W'(S_MIN)) begin
            return S_MIN;
        end
        return DATA_W'(s);
    endfunction

endpackage

### src/lpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the
// line-plane intersection block. Depends on lpi_pkg and the assertion header.
`include "line_plane_intersection_assert.svh"

module lpi_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [lpi_pkg::REM_W-1:0] i_dividend,
    input  logic [lpi_pkg::SUM_W-1:0] i_divisor,
    input  lpi_pkg::t_lpi_side       i_side,
    output logic                     o_valid,
    output logic [lpi_pkg::QUO_W-1:0] o_quot,
    output lpi_pkg::t_lpi_side       o_side
);

    localparam int NS = lpi_pkg::QUO_W;

    logic                      r_vld  [0:NS];
    logic [lpi_pkg::REM_W-1:0] r_rem  [0:NS];
    logic [lpi_pkg::SUM_W-1:0] r_dvs  [0:NS];
    logic [lpi_pkg::QUO_W-1:0] r_q    [0:NS];
    lpi_pkg::t_lpi_side        r_side [0:NS];

    // Valid bits advance every cycle; reset empties the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int j = 0; j < NS; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    // Entry stage takes the operands.
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_dividend;
        r_dvs[0]  <= i_divisor;
        r_q[0]    <= '0;
        r_side[0] <= i_side;
    end

    // Stage j decides quotient bit NS-1-j against the shifted divisor.
    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic [lpi_pkg::TRY_W-1:0] w_trial;
        logic [lpi_pkg::TRY_W-1:0] w_rem;
        logic                      w_take;
        logic [lpi_pkg::REM_W-1:0] n_rem;

        assign w_trial = lpi_pkg::TRY_W'(r_dvs[j]) << K;
        assign w_rem   = lpi_pkg::TRY_W'(r_rem[j]);
        assign w_take  = w_rem >= w_trial;
        assign n_rem   = w_take ? lpi_pkg::REM_W'(w_rem - w_trial) : r_rem[j];

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= n_rem;
            r_dvs[j+1]  <= r_dvs[j];
            r_q[j+1]    <= {r_q[j][lpi_pkg::QUO_W-2:0], w_take};
            r_side[j+1] <= r_side[j];
        end
    end

    assign o_valid = r_vld[NS];
    assign o_quot  = r_q[NS];
    assign o_side  = r_side[NS];

    // Without quotient overflow the final remainder is below the divisor.
    `LPI_ASSERT(a_rem_below_dvs, i_clk, i_rst_n, r_vld[NS] && !r_side[NS].ovf |-> r_rem[NS] < lpi_pkg::REM_W'(r_dvs[NS]), "divider remainder not below divisor")

endmodule

### src/line_plane_intersection.sv
// Top level of the line-plane intersection block: configuration registers,
// dot products, sign handling and hit point. Depends on lpi_pkg and lpi_div.
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  ----------------------
//  line in   start, busy, i_item                           start && !busy
//  result    o_valid, o_result                             o_valid, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,        i_cfg_valid && o_cfg_ready
//            i_cfg_data
//
// One line is taken every cycle; busy stays low and the pipe never stalls.
// The result strobe rises after the line has passed, in order, the products and sums,
// the bit-per-stage divider, then sign, the three t products and the saturating add.
// Reset (synchronous) empties the pipe and restores the plane to z = 0
// with threshold 1; configuration must only change while the pipe is empty.
`include "line_plane_intersection_assert.svh"

module line_plane_intersection (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lpi_pkg::t_lpi_in           i_item,
    output logic                       o_valid,
    output lpi_pkg::t_lpi_out          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lpi_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lpi_pkg::DATA_W-1:0] i_cfg_data
);

    localparam int OUT_DLY = lpi_pkg::QUO_W + 7;

    // Configuration registers.
    logic signed [lpi_pkg::DATA_W-1:0] r_plane_a;
    logic signed [lpi_pkg::DATA_W-1:0] r_plane_b;
    logic signed [lpi_pkg::DATA_W-1:0] r_plane_c;
    logic signed [lpi_pkg::DATA_W-1:0] r_plane_d;
    logic        [lpi_pkg::THR_W-1:0]  r_thr;

    // Pipeline registers.
    logic                              r_p1_vld;
    lpi_pkg::t_lpi_in                  r_p1_item;
    logic                              r_p2_vld;
    lpi_pkg::t_lpi_in                  r_p2_item;
    logic signed [lpi_pkg::PROD_W-1:0] r_p2_ao, r_p2_bo, r_p2_co;
    logic signed [lpi_pkg::PROD_W-1:0] r_p2_av, r_p2_bv, r_p2_cv;
    logic                              r_p3_vld;
    lpi_pkg::t_lpi_in                  r_p3_item;
    logic signed [lpi_pkg::SUM_W-1:0]  r_p3_num, r_p3_den;
    logic                              r_p4_vld;
    lpi_pkg::t_lpi_in                  r_p4_item;
    logic        [lpi_pkg::SUM_W-1:0]  r_p4_anum, r_p4_aden;
    logic                              r_p4_neg, r_p4_par;
    logic                              r_p6_vld;
    lpi_pkg::t_lpi_in                  r_p6_item;
    logic signed [lpi_pkg::DATA_W-1:0] r_p6_t;
    logic                              r_p6_par;
    logic                              r_p7_vld;
    lpi_pkg::t_lpi_in                  r_p7_item;
    logic signed [lpi_pkg::DATA_W-1:0] r_p7_t;
    logic                              r_p7_par;
    logic signed [lpi_pkg::PROD_W-1:0] r_p7_px, r_p7_py, r_p7_pz;
    logic                              r_out_vld;
    lpi_pkg::t_lpi_out                 r_out;

    // Next values.
    logic signed [lpi_pkg::SUM_W-1:0]  n_p3_num, n_p3_den;
    logic        [lpi_pkg::SUM_W-1:0]  n_p4_anum, n_p4_aden;
    logic                              n_p4_neg, n_p4_par;
    lpi_pkg::t_lpi_side                n_side;
    logic signed [lpi_pkg::DATA_W-1:0] n_p6_t;
    lpi_pkg::t_lpi_out                 n_out;

    // Divider interface.
    logic                              w_div_vld;
    logic        [lpi_pkg::QUO_W-1:0]  w_div_q;
    lpi_pkg::t_lpi_side                w_div_side;
    logic signed [lpi_pkg::DATA_W-1:0] w_q_ext;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_a <= '0;
            r_plane_b <= '0;
            r_plane_c <= lpi_pkg::ONE_FIX;
            r_plane_d <= '0;
            r_thr     <= lpi_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpi_pkg::REG_PLANE_A:   r_plane_a <= i_cfg_data;
                lpi_pkg::REG_PLANE_B:   r_plane_b <= i_cfg_data;
                lpi_pkg::REG_PLANE_C:   r_plane_c <= i_cfg_data;
                lpi_pkg::REG_PLANE_D:   r_plane_d <= i_cfg_data;
                lpi_pkg::REG_THRESHOLD: r_thr     <= i_cfg_data[lpi_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the stages outside the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_p7_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_p1_vld  <= start && !busy;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p6_vld  <= w_div_vld;
            r_p7_vld  <= r_p6_vld;
            r_out_vld <= r_p7_vld;
        end
    end

    // Stages one and two: take the line, then the six plane products.
    always_ff @(posedge i_clk) begin
        r_p1_item <= i_item;
        r_p2_item <= r_p1_item;
        r_p2_ao   <= r_plane_a * r_p1_item.origin_x;
        r_p2_bo   <= r_plane_b * r_p1_item.origin_y;
        r_p2_co   <= r_plane_c * r_p1_item.origin_z;
        r_p2_av   <= r_plane_a * r_p1_item.dir_x;
        r_p2_bv   <= r_plane_b * r_p1_item.dir_y;
        r_p2_cv   <= r_plane_c * r_p1_item.dir_z;
    end

    // Stage three: numerator and denominator sums at full width.
    always_comb begin
        n_p3_den = lpi_pkg::fm_ext(r_p2_av) + lpi_pkg::fm_ext(r_p2_bv)
                 + lpi_pkg::fm_ext(r_p2_cv);
        n_p3_num = lpi_pkg::fm_ext(r_p2_ao) + lpi_pkg::fm_ext(r_p2_bo)
                 + lpi_pkg::fm_ext(r_p2_co) + lpi_pkg::SUM_W'(r_plane_d);
    end

    // Stage four: magnitudes, quotient sign and the parallel test.
    always_comb begin
        n_p4_anum = lpi_pkg::abs_sum(r_p3_num);
        n_p4_aden = lpi_pkg::abs_sum(r_p3_den);
        n_p4_neg  = (r_p3_num != '0) && (r_p3_num[lpi_pkg::SUM_W-1] == r_p3_den[lpi_pkg::SUM_W-1]);
        n_p4_par  = (r_p3_den == '0) || (n_p4_aden < lpi_pkg::SUM_W'(r_thr));
    end

    always_ff @(posedge i_clk) begin
        r_p3_item <= r_p2_item;
        r_p3_num  <= n_p3_num;
        r_p3_den  <= n_p3_den;
        r_p4_item <= r_p3_item;
        r_p4_anum <= n_p4_anum;
        r_p4_aden <= n_p4_aden;
        r_p4_neg  <= n_p4_neg;
        r_p4_par  <= n_p4_par;
    end

    // The integer part of t overflows when |num| reaches |den| shifted up.
    always_comb begin
        n_side.item = r_p4_item;
        n_side.neg  = r_p4_neg;
        n_side.par  = r_p4_par;
        n_side.ovf  = lpi_pkg::OVF_W'(r_p4_anum) >= {r_p4_aden, {lpi_pkg::INT_W{1'b0}}};
    end

    lpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_p4_vld),
        .i_dividend ({r_p4_anum, {lpi_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (r_p4_aden),
        .i_side     (n_side),
        .o_valid    (w_div_vld),
        .o_quot     (w_div_q),
        .o_side     (w_div_side)
    );

    // Stage after the divider: signed and saturated t, zero for a parallel line.
    assign w_q_ext = {1'b0, w_div_q};

    always_comb begin
        if (w_div_side.par) begin
            n_p6_t = '0;
        end else if (w_div_side.ovf) begin
            n_p6_t = w_div_side.neg ? lpi_pkg::S_MIN : lpi_pkg::S_MAX;
        end else begin
            n_p6_t = w_div_side.neg ? -w_q_ext : w_q_ext;
        end
    end

    // The three direction-times-t products.
    always_ff @(posedge i_clk) begin
        r_p6_item <= w_div_side.item;
        r_p6_t    <= n_p6_t;
        r_p6_par  <= w_div_side.par;
        r_p7_item <= r_p6_item;
        r_p7_t    <= r_p6_t;
        r_p7_par  <= r_p6_par;
        r_p7_px   <= r_p6_item.dir_x * r_p6_t;
        r_p7_py   <= r_p6_item.dir_y * r_p6_t;
        r_p7_pz   <= r_p6_item.dir_z * r_p6_t;
    end

    // Final stage: saturated hit point, all zero for a parallel line.
    always_comb begin
        if (r_p7_par) begin
            n_out.hit_x = '0;
            n_out.hit_y = '0;
            n_out.hit_z = '0;
        end else begin
            n_out.hit_x = lpi_pkg::add_sat(r_p7_item.origin_x, r_p7_px);
            n_out.hit_y = lpi_pkg::add_sat(r_p7_item.origin_y, r_p7_py);
            n_out.hit_z = lpi_pkg::add_sat(r_p7_item.origin_z, r_p7_pz);
        end
        n_out.line_param = r_p7_t;
        n_out.parallel   = r_p7_par;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // A parallel result carries no hit point and no parameter.
    `LPI_ASSERT(a_par_zero, i_clk, i_rst_n, o_valid && o_result.parallel |-> o_result.hit_x == '0 && o_result.hit_y == '0 && o_result.hit_z == '0 && o_result.line_param == '0, "parallel result with nonzero fields")
    // Every result strobe traces back to a line taken a fixed time earlier.
    `LPI_ASSERT(a_latency, i_clk, i_rst_n, o_valid |-> $past(r_p1_vld, OUT_DLY), "result without a matching transfer in")
    // Reset leaves no result on the port.
    `LPI_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> !o_valid, "result strobe right after reset")

endmodule
